[rtl/stq_pkg.sv]
// Shared types and constants for the sleep timeout queue.
// Used by stq_ctrl, stq_datapath and sleep_timeout_queue; no dependencies.
`timescale 1ns / 1ps

package stq_pkg;

  // Queue geometry
  localparam int MAX_SLEEPERS = 16;
  localparam int IDX_W        = $clog2(MAX_SLEEPERS);
  localparam int CNT_W        = $clog2(MAX_SLEEPERS + 1);

  // At most this many threads are released by one tick
  localparam int RESULTS_CAP  = 16;
  localparam int WAKE_W       = $clog2(RESULTS_CAP + 1);

  // Field widths
  localparam int TICK_W   = 20;
  localparam int US_W     = 32;
  localparam int THREAD_W = 4;
  localparam int SEC_W    = 32;
  localparam int NSEC_W   = 30;
  localparam int NS_W     = 31;  // nanosecond sum before carry into seconds

  // Stream payload widths
  localparam int IN_DATA_W  = 40;  // thread_id, sleep_us, zero fill
  localparam int OUT_DATA_W = 72;  // status, woken_thread, time_sec, time_nsec, zero fill

  // Time constants
  localparam logic [US_W-1:0]   US_LIMIT   = 32'd1000000;
  localparam logic [NS_W-1:0]   NS_PER_SEC = 31'd1000000000;
  localparam logic [NS_W-1:0]   NS_PER_US  = 31'd1000;
  localparam logic [TICK_W-1:0] TICK_RESET = 20'd1000;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_YIELD   = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SLEEP_CHK,
    S_SCAN,
    S_REPLY,
    S_ADVANCE,
    S_CARRY,
    S_WAKE_FIRST,
    S_WAKE_MORE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;        // capture the input item, clear scan and wake counters
    logic    set_status;  // write status register with status
    status_t status;
    logic    scan_inc;    // step the insertion search
    logic    insert;      // insert the item at the search position
    logic    advance;     // add the tick step to both clocks
    logic    carry;       // move one second out of the nanosecond sum
    logic    pop;         // drop the head entry into the pending slot
    logic    emit;        // load the output register
    logic    emit_woken;
    logic    emit_last;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_sleep;   // command field of the item on the input port
    logic us_zero;
    logic us_big;
    logic full;
    logic scan_hit;   // entry at the search position wakes earlier
    logic carry_due;
    logic head_due;   // head entry expired and the wake cap not reached
    logic out_free;
  } stat_t;

endpackage

[rtl/stq_ctrl.sv]
// Controller state machine for the sleep timeout queue.
// Depends on stq_pkg for state, command and status types.
`timescale 1ns / 1ps

module stq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  stq_pkg::stat_t stat,
  output stq_pkg::cmd_t  cmd
);

  stq_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.status = stq_pkg::ST_OK;
    in_ready   = 1'b0;
    case (state)
      stq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = stat.in_sleep ? stq_pkg::S_SLEEP_CHK : stq_pkg::S_ADVANCE;
        end
      end
      // Reject checks in priority order
      stq_pkg::S_SLEEP_CHK: begin
        if (stat.us_zero) begin
          cmd.set_status = 1'b1;
          cmd.status     = stq_pkg::ST_YIELD;
          state_next     = stq_pkg::S_REPLY;
        end else if (stat.us_big) begin
          cmd.set_status = 1'b1;
          cmd.status     = stq_pkg::ST_INVALID;
          state_next     = stq_pkg::S_REPLY;
        end else if (stat.full) begin
          cmd.set_status = 1'b1;
          cmd.status     = stq_pkg::ST_FULL;
          state_next     = stq_pkg::S_REPLY;
        end else begin
          state_next = stq_pkg::S_SCAN;
        end
      end
      // Walk the queue one entry a cycle, insert where the walk stops
      stq_pkg::S_SCAN: begin
        if (stat.scan_hit) begin
          cmd.scan_inc = 1'b1;
        end else begin
          cmd.insert = 1'b1;
          state_next = stq_pkg::S_REPLY;
        end
      end
      stq_pkg::S_REPLY: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_next    = stq_pkg::S_IDLE;
        end
      end
      stq_pkg::S_ADVANCE: begin
        cmd.advance = 1'b1;
        state_next  = stq_pkg::S_CARRY;
      end
      stq_pkg::S_CARRY: begin
        if (stat.carry_due) begin
          cmd.carry = 1'b1;
        end else begin
          state_next = stq_pkg::S_WAKE_FIRST;
        end
      end
      // No thread pending yet
      stq_pkg::S_WAKE_FIRST: begin
        if (stat.head_due) begin
          cmd.pop    = 1'b1;
          state_next = stq_pkg::S_WAKE_MORE;
        end else if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_next    = stq_pkg::S_IDLE;
        end
      end
      // One thread pending; it is last unless another head is due
      stq_pkg::S_WAKE_MORE: begin
        if (stat.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_woken = 1'b1;
          if (stat.head_due) begin
            cmd.pop = 1'b1;
          end else begin
            cmd.emit_last = 1'b1;
            state_next    = stq_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = stq_pkg::S_IDLE;
      end
    endcase
  end

  // The output register is never overwritten while it holds a result
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result emitted while output register busy");

  // Only an expired head is released
  a_pop_due: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> stat.head_due)
    else $error("pop of a head that is not due");

  // No insertion into a full queue
  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !stat.full)
    else $error("insert into full queue");

endmodule

[rtl/stq_datapath.sv]
// Datapath for the sleep timeout queue: sorted entry cells, clocks,
// tick register and output register. Depends on stq_pkg.
`timescale 1ns / 1ps

module stq_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  stq_pkg::cmd_t                   cmd,
  output stq_pkg::stat_t                  stat,
  input  logic [stq_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                            s_tuser,
  input  logic                            cfg_valid,
  input  logic [stq_pkg::TICK_W-1:0]      cfg_data,
  input  logic                            m_tready,
  output logic                            m_tvalid,
  output logic [stq_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                            m_tuser,
  output logic                            m_tlast
);

  // Queue cells, kept sorted by wake time, head at index 0
  logic [stq_pkg::US_W-1:0]     entry_timeout [stq_pkg::MAX_SLEEPERS];
  logic [stq_pkg::THREAD_W-1:0] entry_thread  [stq_pkg::MAX_SLEEPERS];
  logic [stq_pkg::CNT_W-1:0]    entry_count;

  logic [stq_pkg::THREAD_W-1:0] item_thread;
  logic [stq_pkg::US_W-1:0]     item_us;
  logic [stq_pkg::CNT_W-1:0]    scan_pos;
  logic [stq_pkg::WAKE_W-1:0]   wake_cnt;
  logic [stq_pkg::THREAD_W-1:0] pending;
  stq_pkg::status_t             status;

  logic [stq_pkg::TICK_W-1:0]   tick_us;
  logic [stq_pkg::US_W-1:0]     now_us;
  logic [stq_pkg::SEC_W-1:0]    clock_sec;
  logic [stq_pkg::NS_W-1:0]     clock_ns;

  logic [stq_pkg::US_W-1:0]     scan_left;
  logic [stq_pkg::US_W-1:0]     head_left;
  logic [stq_pkg::US_W-1:0]     new_timeout;

  // Remaining time at the search position and at the head
  assign scan_left   = entry_timeout[scan_pos[stq_pkg::IDX_W-1:0]] - now_us;
  assign head_left   = entry_timeout[0] - now_us;
  assign new_timeout = now_us + item_us;

  // Status toward the controller
  always_comb begin
    stat.in_sleep  = s_tuser;
    stat.us_zero   = (item_us == '0);
    stat.us_big    = (item_us > stq_pkg::US_LIMIT);
    stat.full      = (entry_count == stq_pkg::CNT_W'(stq_pkg::MAX_SLEEPERS));
    stat.scan_hit  = (scan_pos < entry_count) && (scan_left < item_us);
    stat.carry_due = (clock_ns >= stq_pkg::NS_PER_SEC);
    stat.head_due  = (entry_count != '0)
                     && ((head_left == '0) || head_left[stq_pkg::US_W-1])
                     && (wake_cnt != stq_pkg::WAKE_W'(stq_pkg::RESULTS_CAP));
    stat.out_free  = !m_tvalid || m_tready;
  end

  // Item capture, search and wake bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pos <= '0;
      wake_cnt <= '0;
      status   <= stq_pkg::ST_OK;
    end else if (cmd.load) begin
      scan_pos <= '0;
      wake_cnt <= '0;
      status   <= stq_pkg::ST_OK;
    end else begin
      if (cmd.scan_inc) begin
        scan_pos <= scan_pos + 1'b1;
      end
      if (cmd.pop) begin
        wake_cnt <= wake_cnt + 1'b1;
      end
      if (cmd.set_status) begin
        status <= cmd.status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_thread <= s_tdata[stq_pkg::THREAD_W-1:0];
      item_us     <= s_tdata[stq_pkg::THREAD_W +: stq_pkg::US_W];
    end
    if (cmd.pop) begin
      pending <= entry_thread[0];
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.insert) begin
      entry_count <= entry_count + 1'b1;
    end else if (cmd.pop) begin
      entry_count <= entry_count - 1'b1;
    end
  end

  // Cell shifting: insert moves the tail up, pop moves everything down
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (scan_pos == '0) begin
        entry_timeout[0] <= new_timeout;
        entry_thread[0]  <= item_thread;
      end
      for (int i = 1; i < stq_pkg::MAX_SLEEPERS; i++) begin
        if (stq_pkg::CNT_W'(i) == scan_pos) begin
          entry_timeout[i] <= new_timeout;
          entry_thread[i]  <= item_thread;
        end else if (stq_pkg::CNT_W'(i) > scan_pos) begin
          entry_timeout[i] <= entry_timeout[i-1];
          entry_thread[i]  <= entry_thread[i-1];
        end
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < stq_pkg::MAX_SLEEPERS - 1; i++) begin
        entry_timeout[i] <= entry_timeout[i+1];
        entry_thread[i]  <= entry_thread[i+1];
      end
    end
  end

  // Tick step register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_us <= stq_pkg::TICK_RESET;
    end else if (cfg_valid) begin
      tick_us <= cfg_data;
    end
  end

  // Clocks: add the step, then carry whole seconds one per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      now_us    <= '0;
      clock_sec <= '0;
      clock_ns  <= '0;
    end else if (cmd.advance) begin
      now_us   <= now_us + stq_pkg::US_W'(tick_us);
      clock_ns <= clock_ns + stq_pkg::NS_W'(tick_us) * stq_pkg::NS_PER_US;
    end else if (cmd.carry) begin
      clock_ns  <= clock_ns - stq_pkg::NS_PER_SEC;
      clock_sec <= clock_sec + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {4'b0000,
                  clock_ns[stq_pkg::NSEC_W-1:0],
                  clock_sec,
                  cmd.emit_woken ? pending : stq_pkg::THREAD_W'(0),
                  status};
      m_tuser <= cmd.emit_woken;
      m_tlast <= cmd.emit_last;
    end
  end

  // Queue never holds more entries than cells
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= stq_pkg::CNT_W'(stq_pkg::MAX_SLEEPERS))
    else $error("entry count beyond queue depth");

  // Wake counter stays within the per-tick cap
  a_wake_cap: assert property (@(posedge clk) disable iff (rst)
    wake_cnt <= stq_pkg::WAKE_W'(stq_pkg::RESULTS_CAP))
    else $error("wake count beyond cap");

  // Reported nanoseconds are always carried fully into seconds
  a_nsec_carried: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> clock_ns < stq_pkg::NS_PER_SEC)
    else $error("result emitted with uncarried nanoseconds");

endmodule

[rtl/sleep_timeout_queue.sv]
// Top level of the sleep timeout queue: sorted timer queue with clocks.
// Instantiates stq_ctrl and stq_datapath; types from stq_pkg.
//
//  channel  direction  handshake           payload
//  s_*      in         s_tvalid/s_tready   tuser: command; tdata: thread_id, sleep_us
//  m_*      out        m_tvalid/m_tready   tuser: woken_valid; tlast: last;
//                                          tdata: status, woken_thread, time_sec, time_nsec
//  cfg_*    in         cfg_valid/cfg_ready cfg_data: tick_us, always ready
//
// Sleep request: range and room checks, then an insertion search that walks the queued
// entries (up to MAX_SLEEPERS - 1), then the reply; rejects skip the search.
// Tick: advance both clocks, carry whole seconds (at most 2), release expired threads
// (at most 16) or send one empty result; the sequencer handles one item at a time.
// Reset (rst, synchronous) empties the queue, zeroes the clocks, sets tick_us to 1000.
// A stalled output holds the sequencer; a new item is taken while the last result waits.
`timescale 1ns / 1ps

module sleep_timeout_queue (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [stq_pkg::IN_DATA_W-1:0]   s_tdata,   // [3:0] thread_id, [35:4] sleep_us
  input  logic                            s_tuser,   // [0] command
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [stq_pkg::OUT_DATA_W-1:0]  m_tdata,   // [1:0] status, [5:2] woken_thread,
                                                     // [37:6] time_sec, [67:38] time_nsec
  output logic                            m_tuser,   // [0] woken_valid
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [stq_pkg::TICK_W-1:0]      cfg_data   // tick_us
);

  stq_pkg::cmd_t  cmd;
  stq_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  // Sequencer
  stq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Queue cells, clocks and output register
  stq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

[tb/tb.sv]
// Self-checking bench for sleep_timeout_queue: directed rows, then random phases per tick step.
// Depends on stq_pkg and the sleep_timeout_queue RTL; expected results come from a local model.
`timescale 1ns / 1ps

module tb;
  import stq_pkg::*;

  localparam bit CMD_TICK  = 1'b0;
  localparam bit CMD_SLEEP = 1'b1;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 30;

  // One result as seen on the master side
  typedef struct {
    status_t               status;
    bit                    woken;
    logic [THREAD_W-1:0]   thread;
    bit                    last_flag;
    logic [SEC_W-1:0]      sec;
    logic [NSEC_W-1:0]     nsec;
  } wake_report_t;

  // Directed request; typed rows carry their expected single result
  typedef struct {
    bit                    cmd;
    logic [THREAD_W-1:0]   thread;
    logic [US_W-1:0]       us;
    bit                    typed;
    status_t               status;
    logic [SEC_W-1:0]      sec;
    logic [NSEC_W-1:0]     nsec;
  } stim_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [IN_DATA_W-1:0]    s_tdata = '0;
  logic                    s_tuser = 1'b0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_tdata;
  logic                    m_tuser;
  logic                    m_tlast;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [TICK_W-1:0]       cfg_data = '0;

  sleep_timeout_queue dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Model state: sorted sleepers, microsecond clock, seconds/nanoseconds clock
  logic [US_W-1:0]       sleeper_wake[MAX_SLEEPERS];
  logic [THREAD_W-1:0]   sleeper_id[MAX_SLEEPERS];
  int                    sleeper_count = 0;
  logic [US_W-1:0]       cur_us = '0;
  logic [SEC_W-1:0]      sec_count = '0;
  logic [NSEC_W-1:0]     nsec_count = '0;
  logic [TICK_W-1:0]     step_us = TICK_RESET;

  wake_report_t          pending_reports[$];
  stim_row_t             directed_rows[$];
  wake_report_t          seen_report;
  int                    fail_count = 0;
  int                    cycle_count = 0;
  int                    rx_hold = 0;
  int                    rx_draw;
  bit                    no_idle = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic void push_report(status_t st, bit woken, logic [THREAD_W-1:0] thread,
                                      bit last_flag);
    wake_report_t rep;
    rep.status    = st;
    rep.woken     = woken;
    rep.thread    = thread;
    rep.last_flag = last_flag;
    rep.sec       = sec_count;
    rep.nsec      = nsec_count;
    pending_reports.push_back(rep);
  endfunction

  // Sleep request: reject or insert before the first entry with remaining time >= us
  function automatic status_t model_sleep(logic [THREAD_W-1:0] thread, logic [US_W-1:0] us);
    int pos;
    int i;
    if (us == 0) return ST_YIELD;
    if (us > US_LIMIT) return ST_INVALID;
    if (sleeper_count >= MAX_SLEEPERS) return ST_FULL;
    pos = 0;
    while (pos < sleeper_count && US_W'(sleeper_wake[pos] - cur_us) < us) pos++;
    for (i = sleeper_count; i > pos; i--) begin
      sleeper_wake[i] = sleeper_wake[i-1];
      sleeper_id[i]   = sleeper_id[i-1];
    end
    sleeper_wake[pos] = cur_us + us;
    sleeper_id[pos]   = thread;
    sleeper_count++;
    return ST_OK;
  endfunction

  // Tick: advance both clocks, then release expired heads up to the cap
  function automatic void model_tick();
    logic [63:0]         ns;
    logic [US_W-1:0]     remaining;
    logic [THREAD_W-1:0] woken[$];
    int                  i;
    ns = 64'(nsec_count) + 64'(step_us) * 64'(NS_PER_US);
    cur_us = cur_us + US_W'(step_us);
    while (ns >= 64'(NS_PER_SEC)) begin
      ns = ns - 64'(NS_PER_SEC);
      sec_count = sec_count + 1;
    end
    nsec_count = ns[NSEC_W-1:0];
    while (sleeper_count > 0 && woken.size() < RESULTS_CAP) begin
      remaining = sleeper_wake[0] - cur_us;
      if (remaining != 0 && !remaining[US_W-1]) break;
      woken.push_back(sleeper_id[0]);
      for (i = 1; i < sleeper_count; i++) begin
        sleeper_wake[i-1] = sleeper_wake[i];
        sleeper_id[i-1]   = sleeper_id[i];
      end
      sleeper_count--;
    end
    if (woken.size() == 0) push_report(ST_OK, 1'b0, '0, 1'b1);
    for (i = 0; i < woken.size(); i++) push_report(ST_OK, 1'b1, woken[i], i == woken.size() - 1);
  endfunction

  function automatic void check_report(wake_report_t got);
    wake_report_t want;
    if (pending_reports.size() == 0) begin
      $error("unexpected result: status %0d woken_thread %0d", got.status, got.thread);
      fail_count++;
      return;
    end
    want = pending_reports.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      fail_count++;
    end
    if (got.woken !== want.woken) begin
      $error("woken_valid: expected %0d, got %0d", want.woken, got.woken);
      fail_count++;
    end
    if (got.thread !== want.thread) begin
      $error("woken_thread: expected %0d, got %0d", want.thread, got.thread);
      fail_count++;
    end
    if (got.last_flag !== want.last_flag) begin
      $error("last: expected %0d, got %0d", want.last_flag, got.last_flag);
      fail_count++;
    end
    if (got.sec !== want.sec) begin
      $error("time_sec: expected %0d, got %0d", want.sec, got.sec);
      fail_count++;
    end
    if (got.nsec !== want.nsec) begin
      $error("time_nsec: expected %0d, got %0d", want.nsec, got.nsec);
      fail_count++;
    end
  endfunction

  // Result side: check each accepted result, then stall for a random count
  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      seen_report.status    = status_t'(m_tdata[1:0]);
      seen_report.thread    = m_tdata[5:2];
      seen_report.sec       = m_tdata[37:6];
      seen_report.nsec      = m_tdata[67:38];
      seen_report.woken     = m_tuser;
      seen_report.last_flag = m_tlast;
      check_report(seen_report);
      rx_draw = draw_gap();
      m_tready <= (rx_draw == 0);
      rx_hold <= rx_draw;
    end else if (!m_tready) begin
      if (rx_hold <= 1) m_tready <= 1'b1;
      rx_hold <= (rx_hold > 0) ? rx_hold - 1 : 0;
    end
  end

  // Send one request; s_tvalid stays high across back-to-back requests
  task automatic send_request(bit cmd, logic [THREAD_W-1:0] thread, logic [US_W-1:0] us);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {4'b0, us, thread};
    do @(posedge clk); while (!s_tready);
    if (cmd == CMD_SLEEP) push_report(model_sleep(thread, us), 1'b0, '0, 1'b1);
    else model_tick();
  endtask

  // Hold off the sender until every result is in and the block has settled
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tick_step(logic [TICK_W-1:0] step);
    cfg_valid <= 1'b1;
    cfg_data  <= step;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    step_us = step;
  endtask

  function automatic void add_row(bit cmd, logic [THREAD_W-1:0] thread, logic [US_W-1:0] us,
                                  bit typed, status_t st, logic [SEC_W-1:0] sec,
                                  logic [NSEC_W-1:0] nsec);
    stim_row_t row;
    row.cmd    = cmd;
    row.thread = thread;
    row.us     = us;
    row.typed  = typed;
    row.status = st;
    row.sec    = sec;
    row.nsec   = nsec;
    directed_rows.push_back(row);
  endfunction

  // Random requests: ticks, sleeps of many lengths, some scaled to the tick step, bursts that can fill the queue
  task automatic run_random_phase(int budget);
    int              done;
    int              pick;
    int              burst_len;
    logic [US_W-1:0] span;
    logic [US_W-1:0] burst_span;
    span = (step_us == 0) ? US_W'(1000) :
           ((US_W'(step_us) * 3 > US_LIMIT) ? US_LIMIT : US_W'(step_us) * 3);
    burst_span = (step_us == 0) ? US_W'(1) :
                 ((US_W'(step_us) > US_LIMIT) ? US_LIMIT : US_W'(step_us));
    done = 0;
    while (done < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // up to 17 short sleeps, which can fill the queue, then one tick releases a crowd
        burst_len = $urandom_range(8, 17);
        repeat (burst_len)
          send_request(CMD_SLEEP, $urandom_range(0, 15), $urandom_range(1, burst_span));
        send_request(CMD_TICK, $urandom_range(0, 15), $urandom());
        done += burst_len + 1;
      end else begin
        if (pick < 45)
          send_request(CMD_TICK, $urandom_range(0, 15), $urandom());
        else if (pick < 50)
          send_request(CMD_SLEEP, $urandom_range(0, 15), '0);
        else if (pick < 55)
          send_request(CMD_SLEEP, $urandom_range(0, 15),
                       $urandom_range(US_LIMIT + 1, 32'hFFFF_FFFF));
        else if (pick < 65)
          send_request(CMD_SLEEP, $urandom_range(0, 15), $urandom_range(1, US_LIMIT));
        else
          send_request(CMD_SLEEP, $urandom_range(0, 15), $urandom_range(1, span));
        done++;
      end
    end
  endtask

  initial begin
    logic [TICK_W-1:0] step_list[6];
    int                p;
    step_list = '{20'd1, 20'hFFFFF, 20'd0, 20'd1000000, 20'd0, 20'd1000};
    step_list[4] = $urandom_range(1, 1000000);

    // Directed rows; clock reads 0 s / 1000000 ns after the first tick at the reset step
    add_row(CMD_TICK,  4'd0,  32'd0,          1, ST_OK,      0, 30'd1000000);
    add_row(CMD_SLEEP, 4'd0,  32'd0,          1, ST_YIELD,   0, 30'd1000000);
    add_row(CMD_SLEEP, 4'd15, 32'd1000001,    1, ST_INVALID, 0, 30'd1000000);
    add_row(CMD_SLEEP, 4'd15, 32'hFFFF_FFFF,  1, ST_INVALID, 0, 30'd1000000);
    add_row(CMD_SLEEP, 4'd5,  32'd1,          1, ST_OK,      0, 30'd1000000);
    // duplicate thread, equal wake times, shortest and longest legal sleeps
    add_row(CMD_SLEEP, 4'd5,  32'd1,          0, ST_OK, 0, 0);
    add_row(CMD_SLEEP, 4'd7,  32'd1000,       0, ST_OK, 0, 0);
    add_row(CMD_SLEEP, 4'd9,  32'd1000,       0, ST_OK, 0, 0);
    add_row(CMD_SLEEP, 4'd3,  32'd1000000,    0, ST_OK, 0, 0);
    add_row(CMD_SLEEP, 4'd0,  32'd500,        0, ST_OK, 0, 0);
    add_row(CMD_SLEEP, 4'd1,  32'd999,        0, ST_OK, 0, 0);
    add_row(CMD_SLEEP, 4'd2,  32'd1,          0, ST_OK, 0, 0);
    add_row(CMD_SLEEP, 4'd4,  32'd2000,       0, ST_OK, 0, 0);
    add_row(CMD_SLEEP, 4'd6,  32'd750,        0, ST_OK, 0, 0);
    add_row(CMD_SLEEP, 4'd8,  32'd1000,       0, ST_OK, 0, 0);
    add_row(CMD_SLEEP, 4'd10, 32'd250,        0, ST_OK, 0, 0);
    add_row(CMD_SLEEP, 4'd11, 32'd999999,     0, ST_OK, 0, 0);
    add_row(CMD_SLEEP, 4'd12, 32'd1000,       0, ST_OK, 0, 0);
    add_row(CMD_SLEEP, 4'd13, 32'd3,          0, ST_OK, 0, 0);
    add_row(CMD_SLEEP, 4'd14, 32'd1000,       0, ST_OK, 0, 0);
    // sixteen queued: the next request is dropped
    add_row(CMD_SLEEP, 4'd15, 32'd1,          1, ST_FULL,    0, 30'd1000000);
    add_row(CMD_TICK,  4'd15, 32'hFFFF_FFFF,  0, ST_OK, 0, 0);
    add_row(CMD_TICK,  4'd0,  32'd0,          0, ST_OK, 0, 0);
    add_row(CMD_TICK,  4'd0,  32'd0,          0, ST_OK, 0, 0);
    add_row(CMD_SLEEP, 4'd10, 32'd1000000,    0, ST_OK, 0, 0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].cmd, directed_rows[i].thread, directed_rows[i].us);
      if (directed_rows[i].typed) begin
        void'(pending_reports.pop_back());
        pending_reports.push_back('{directed_rows[i].status, 1'b0, '0, 1'b1,
                                   directed_rows[i].sec, directed_rows[i].nsec});
      end
    end
    wait_idle();

    // Random phases, one tick step each; two of them run without idling
    for (p = 0; p < 6; p++) begin
      write_tick_step(step_list[p]);
      no_idle = (p == 2 || p == 4);
      run_random_phase(PHASE_ITEMS);
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
